@@ sv/abs_pkg.sv @@
// Package for the alert blink sequencer: constants, codes and payload types.
package abs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ENQUEUE = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RING    = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUED_BLINK_COUNT = 3'd0,
        CFG_QUEUED_PERIOD      = 3'd1,
        CFG_FIRST_COLOR        = 3'd2,
        CFG_SECOND_COLOR       = 3'd3,
        CFG_LIT_LEVEL_HIGH     = 3'd4
    } cfg_idx_t;

    localparam logic [7:0]  RST_QUEUED_BLINK_COUNT = 8'd3;
    localparam logic [15:0] RST_QUEUED_PERIOD      = 16'd500;
    localparam logic [2:0]  RST_FIRST_COLOR        = 3'd4;
    localparam logic [2:0]  RST_SECOND_COLOR       = 3'd1;
    localparam logic [2:0]  RST_BLINK_COLOR        = 3'd4;
    localparam logic [15:0] ELAPSED_MAX            = 16'hFFFF;

    typedef logic [1:0] qentry_t;
    typedef qentry_t [QUEUE_DEPTH-1:0] queue_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  compartment;
        logic [7:0]  blink_times;
        logic [15:0] period_ticks;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
    } in_item_t;

    typedef struct packed {
        logic       red_pin;
        logic       green_pin;
        logic       blue_pin;
        logic       buzzer_on;
        logic       is_ringing;
        logic       blinking;
        logic [2:0] queued_count;
    } out_item_t;

endpackage

@@ sv/alert_blink_sequencer.sv @@
// Alert blink sequencer top level: request decode, blink state, pending queue, status register.
//
// One request (tick, enqueue, direct start, stop, start ringing) is taken per clock while the
// status register is free or being taken; its status appears in the output register on the next
// cycle, and a new request is taken in the same cycle that the waiting status is taken.
// Throughput is one request per cycle while out_ready holds. Ticks are one-millisecond events
// supplied as requests; the pending queue holds up to QUEUE_DEPTH compartments, drops duplicates
// and overflow, and a zero blink count stays lit until stopped. Configuration writes must be made
// only while no request is in flight; the block itself does not enforce this.
module alert_blink_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  abs_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output abs_pkg::out_item_t                  out_data,
    input  logic                                cfg_write,
    input  logic [abs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [abs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import abs_pkg::*;

    logic [7:0]       qcount_cfg_reg;
    logic [15:0]      qperiod_cfg_reg;
    logic [2:0]       first_color_reg;
    logic [2:0]       second_color_reg;
    logic             lit_high_reg;

    logic             ring_reg,    ring_next;
    logic             run_reg,     run_next;
    logic             phase_reg,   phase_next;
    logic [8:0]       toggles_reg, toggles_next;
    logic [15:0]      period_reg,  period_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [2:0]       color_reg,   color_next;
    queue_t           queue_reg,   queue_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;

    logic             out_valid_reg;
    out_item_t        out_data_reg, out_data_next;
    logic             accept;

    function automatic queue_t qpop(input queue_t q);
        queue_t r;
        r = q;
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            r[i-1] = q[i];
        end
        return r;
    endfunction

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_cfg_reg   <= RST_QUEUED_BLINK_COUNT;
            qperiod_cfg_reg  <= RST_QUEUED_PERIOD;
            first_color_reg  <= RST_FIRST_COLOR;
            second_color_reg <= RST_SECOND_COLOR;
            lit_high_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_QUEUED_BLINK_COUNT: qcount_cfg_reg   <= cfg_data[7:0];
                CFG_QUEUED_PERIOD:      qperiod_cfg_reg  <= cfg_data[15:0];
                CFG_FIRST_COLOR:        first_color_reg  <= cfg_data[2:0];
                CFG_SECOND_COLOR:       second_color_reg <= cfg_data[2:0];
                CFG_LIT_LEVEL_HIGH:     lit_high_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic    dup;
        qentry_t comp;
        qentry_t head;
        logic    lit;
        logic [2:0] mask;
        logic [2:0] pins;

        ring_next    = ring_reg;
        run_next     = run_reg;
        phase_next   = phase_reg;
        toggles_next = toggles_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        color_next   = color_reg;
        queue_next   = queue_reg;
        cnt_next     = cnt_reg;
        dup          = 1'b0;
        comp         = 2'd1;
        head         = queue_reg[0];

        unique case (in_data.op)
            OP_TICK:
            begin
                if (run_next && elapsed_next != ELAPSED_MAX)
                    elapsed_next = elapsed_next + 16'd1;
                if (!run_next && cnt_next != '0)
                begin
                    head         = queue_next[0];
                    queue_next   = qpop(queue_next);
                    cnt_next     = cnt_next - CNT_W'(1);
                    color_next   = (head <= 2'd1) ? first_color_reg : second_color_reg;
                    ring_next    = 1'b1;
                    run_next     = 1'b1;
                    toggles_next = {qcount_cfg_reg, 1'b0};
                    period_next  = qperiod_cfg_reg;
                    elapsed_next = '0;
                    phase_next   = 1'b1;
                end
                if (run_next && toggles_next != '0 && elapsed_next >= period_next)
                begin
                    elapsed_next = '0;
                    toggles_next = toggles_next - 9'd1;
                    phase_next   = !phase_next;
                    if (toggles_next == '0)
                    begin
                        ring_next  = 1'b0;
                        run_next   = 1'b0;
                        phase_next = 1'b0;
                        if (cnt_next != '0)
                        begin
                            head         = queue_next[0];
                            queue_next   = qpop(queue_next);
                            cnt_next     = cnt_next - CNT_W'(1);
                            color_next   = (head <= 2'd1) ? first_color_reg
                                                          : second_color_reg;
                            ring_next    = 1'b1;
                            run_next     = 1'b1;
                            toggles_next = {qcount_cfg_reg, 1'b0};
                            period_next  = qperiod_cfg_reg;
                            elapsed_next = '0;
                            phase_next   = 1'b1;
                        end
                    end
                end
            end
            OP_ENQUEUE:
            begin
                if (in_data.compartment == 4'd0)
                    comp = 2'd1;
                else if (in_data.compartment > 4'd2)
                    comp = 2'd2;
                else
                    comp = in_data.compartment[1:0];
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (CNT_W'(i) < cnt_reg && queue_reg[i] == comp)
                        dup = 1'b1;
                end
                if (!dup && cnt_reg < CNT_W'(QUEUE_DEPTH))
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (CNT_W'(i) == cnt_reg)
                            queue_next[i] = comp;
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (!run_reg && !ring_reg)
                    begin
                        head         = queue_next[0];
                        queue_next   = qpop(queue_next);
                        cnt_next     = cnt_next - CNT_W'(1);
                        color_next   = (head <= 2'd1) ? first_color_reg : second_color_reg;
                        ring_next    = 1'b1;
                        run_next     = 1'b1;
                        toggles_next = {qcount_cfg_reg, 1'b0};
                        period_next  = qperiod_cfg_reg;
                        elapsed_next = '0;
                        phase_next   = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                color_next   = {in_data.red_level != 8'd0,
                                in_data.green_level != 8'd0,
                                in_data.blue_level != 8'd0};
                ring_next    = 1'b1;
                run_next     = 1'b1;
                toggles_next = {in_data.blink_times, 1'b0};
                period_next  = in_data.period_ticks;
                elapsed_next = '0;
                phase_next   = 1'b1;
            end
            OP_STOP:
            begin
                ring_next  = 1'b0;
                run_next   = 1'b0;
                phase_next = 1'b0;
            end
            OP_RING:
            begin
                ring_next = 1'b1;
            end
            default: ;
        endcase

        lit  = run_next && phase_next;
        mask = lit ? color_next : 3'd0;
        pins = lit_high_reg ? mask : ~mask;
        out_data_next.red_pin      = pins[2];
        out_data_next.green_pin    = pins[1];
        out_data_next.blue_pin     = pins[0];
        out_data_next.buzzer_on    = lit;
        out_data_next.is_ringing   = ring_next;
        out_data_next.blinking     = run_next;
        out_data_next.queued_count = 3'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg      <= 1'b0;
            run_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            toggles_reg   <= '0;
            period_reg    <= '0;
            elapsed_reg   <= '0;
            color_reg     <= RST_BLINK_COLOR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ring_reg    <= ring_next;
                run_reg     <= run_next;
                phase_reg   <= phase_next;
                toggles_reg <= toggles_next;
                period_reg  <= period_next;
                elapsed_reg <= elapsed_next;
                color_reg   <= color_next;
                cnt_reg     <= cnt_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg    <= queue_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ sv/abs_checker.sv @@
// Port-level checks for the alert blink sequencer and their bind to the top level.
module abs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  abs_pkg::out_item_t                  out_data
);
    import abs_pkg::*;

    // every accepted request yields a status on the next cycle
    a_req_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request produced no status");

    // a stalled status holds
    a_status_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled status changed");

    // buzzer only sounds inside a running, ringing blink
    a_buzzer_in_blink: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.buzzer_on |-> out_data.blinking && out_data.is_ringing)
        else $error("buzzer on outside a blink");

    // a running blink always reports ringing
    a_blink_rings: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.blinking |-> out_data.is_ringing)
        else $error("blink running without ringing");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.queued_count <= 3'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

bind alert_blink_sequencer abs_checker u_abs_checker (.*);

@@ tb/tb_alert_blink_sequencer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for alert_blink_sequencer: directed table, random requests, status predictor.
module tb_alert_blink_sequencer;
    import abs_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_REQUESTS = 200;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // typed-in expectation travelling with the request being offered
    bit req_typed;
    out_item_t req_want;

    // predictor state and register copies
    logic [7:0] cfg_count;
    logic [15:0] cfg_period;
    logic [2:0] cfg_color1;
    logic [2:0] cfg_color2;
    logic cfg_lit_high;
    logic ringing;
    logic running;
    logic lit_phase;
    logic [8:0] toggles;
    logic [15:0] period_now;
    logic [15:0] elapsed;
    logic [2:0] color_now;
    qentry_t pend_q [QUEUE_DEPTH];
    logic [CNT_W-1:0] pend_n;

    out_item_t status_due [$];
    script_row_t script [$];
    int errors = 0;
    int requests_sent = 0;
    int statuses_checked = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;

    alert_blink_sequencer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void launch_blink(input logic [7:0] times, input logic [15:0] per,
                                         input logic [2:0] col);
        color_now = col;
        ringing = 1'b1;
        running = 1'b1;
        toggles = {times, 1'b0};
        period_now = per;
        elapsed = '0;
        lit_phase = 1'b1;
    endfunction

    function automatic void start_queued_head();
        qentry_t head;
        if (running || pend_n == 0)
            return;
        head = pend_q[0];
        for (int i = 1; i < QUEUE_DEPTH; i++)
            pend_q[i-1] = pend_q[i];
        pend_n--;
        launch_blink(cfg_count, cfg_period, (head <= 2'd1) ? cfg_color1 : cfg_color2);
    endfunction

    function automatic out_item_t predict_status(input in_item_t r);
        qentry_t comp;
        logic dup;
        logic lit;
        logic [2:0] mask;
        case (r.op)
            OP_TICK:
            begin
                if (running && elapsed != ELAPSED_MAX)
                    elapsed++;
                if (!running && pend_n > 0)
                    start_queued_head();
                if (running && toggles != 0 && elapsed >= period_now)
                begin
                    elapsed = '0;
                    toggles--;
                    lit_phase = !lit_phase;
                    if (toggles == 0)
                    begin
                        ringing = 1'b0;
                        running = 1'b0;
                        lit_phase = 1'b0;
                        start_queued_head();
                    end
                end
            end
            OP_ENQUEUE:
            begin
                if (r.compartment == 0)
                    comp = 2'd1;
                else if (r.compartment > 2)
                    comp = 2'd2;
                else
                    comp = r.compartment[1:0];
                dup = 1'b0;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (i < pend_n && pend_q[i] == comp)
                        dup = 1'b1;
                if (!dup && pend_n < QUEUE_DEPTH)
                begin
                    pend_q[pend_n] = comp;
                    pend_n++;
                    if (!running && !ringing)
                        start_queued_head();
                end
            end
            OP_START:
                launch_blink(r.blink_times, r.period_ticks,
                             {r.red_level != 0, r.green_level != 0, r.blue_level != 0});
            OP_STOP:
            begin
                ringing = 1'b0;
                running = 1'b0;
                lit_phase = 1'b0;
            end
            OP_RING:
                ringing = 1'b1;
            default:
                ;
        endcase
        lit = running && lit_phase;
        mask = lit ? color_now : 3'd0;
        if (!cfg_lit_high)
            mask = ~mask;
        return out_item_t'({mask, lit, ringing, running, 3'(pend_n)});
    endfunction

    function automatic in_item_t make_req(input logic [2:0] op, input logic [3:0] comp,
                                          input logic [7:0] times, input logic [15:0] per,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        return in_item_t'({op, comp, times, per, r, g, b});
    endfunction

    function automatic out_item_t status(input bit r, input bit g, input bit b, input bit buz,
                                         input bit ring, input bit blk, input logic [2:0] q);
        return out_item_t'({r, g, b, buz, ring, blk, q});
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        int pick;
        r.compartment = 4'($urandom);
        r.blink_times = 8'($urandom);
        r.period_ticks = 16'($urandom);
        r.red_level = 8'($urandom);
        r.green_level = 8'($urandom);
        r.blue_level = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
            r.op = OP_TICK;
        else if (pick < 70)
            r.op = OP_ENQUEUE;
        else if (pick < 80)
            r.op = OP_START;
        else if (pick < 88)
            r.op = OP_STOP;
        else if (pick < 95)
            r.op = OP_RING;
        else
            r.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        // short blinks mostly, so queued requests get their turn
        if ($urandom_range(15) != 0)
        begin
            r.blink_times = 8'($urandom_range(3));
            r.period_ticks = 16'($urandom_range(4));
        end
        if ($urandom_range(2) == 0)
            r.red_level = '0;
        if ($urandom_range(2) == 0)
            r.green_level = '0;
        if ($urandom_range(2) == 0)
            r.blue_level = '0;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status %h with no request outstanding", out_data);
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    statuses_checked++;
                    check_field("red_pin", want.red_pin, out_data.red_pin);
                    check_field("green_pin", want.green_pin, out_data.green_pin);
                    check_field("blue_pin", want.blue_pin, out_data.blue_pin);
                    check_field("buzzer_on", want.buzzer_on, out_data.buzzer_on);
                    check_field("is_ringing", want.is_ringing, out_data.is_ringing);
                    check_field("blinking", want.blinking, out_data.blinking);
                    check_field("queued_count", want.queued_count, out_data.queued_count);
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_status(in_data);
                status_due.push_back(req_typed ? req_want : want);
            end
        end
    end

    task automatic send_request(input in_item_t req, input bit typed, input out_item_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        req_typed <= typed;
        req_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // let the scoreboard log the last accepted request first
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] cnt, input logic [15:0] per,
                                 input logic [2:0] c1, input logic [2:0] c2, input logic lit);
        write_reg(CFG_QUEUED_BLINK_COUNT, 16'(cnt));
        write_reg(CFG_QUEUED_PERIOD, per);
        write_reg(CFG_FIRST_COLOR, 16'(c1));
        write_reg(CFG_SECOND_COLOR, 16'(c2));
        write_reg(CFG_LIT_LEVEL_HIGH, 16'(lit));
        cfg_write <= 1'b0;
        cfg_count = cnt;
        cfg_period = per;
        cfg_color1 = c1;
        cfg_color2 = c2;
        cfg_lit_high = lit;
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_alert_blink_sequencer: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        req_typed = 1'b0;
        req_want = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_QUEUED_BLINK_COUNT;
        cfg_data = '0;

        cfg_count = RST_QUEUED_BLINK_COUNT;
        cfg_period = RST_QUEUED_PERIOD;
        cfg_color1 = RST_FIRST_COLOR;
        cfg_color2 = RST_SECOND_COLOR;
        cfg_lit_high = 1'b0;
        ringing = 1'b0;
        running = 1'b0;
        lit_phase = 1'b0;
        toggles = '0;
        period_now = '0;
        elapsed = '0;
        color_now = RST_BLINK_COLOR;
        pend_n = '0;
        foreach (pend_q[i])
            pend_q[i] = '0;

        // reset settings: LED active low, compartment one red, two blue
        script.push_back(script_row_t'{make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 0, 0, 0, 0)});
        script.push_back(script_row_t'{make_req(OP_SPARE_LO, 4'hF, 8'hFF, 16'hFFFF, 8'hFF,
                                                8'hFF, 8'hFF), 1'b1, status(1, 1, 1, 0, 0, 0, 0)});
        script.push_back(script_row_t'{make_req(OP_SPARE_HI, 0, 0, 0, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 0, 0, 0, 0)});
        script.push_back(script_row_t'{make_req(OP_RING, 0, 0, 0, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 0, 1, 0, 0)});
        script.push_back(script_row_t'{make_req(OP_STOP, 0, 0, 0, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 0, 0, 0, 0)});
        // compartment zero clamps to one and starts at once
        script.push_back(script_row_t'{make_req(OP_ENQUEUE, 0, 0, 0, 0, 0, 0), 1'b1,
                                       status(0, 1, 1, 1, 1, 1, 0)});
        script.push_back(script_row_t'{make_req(OP_ENQUEUE, 15, 0, 0, 0, 0, 0), 1'b1,
                                       status(0, 1, 1, 1, 1, 1, 1)});
        script.push_back(script_row_t'{make_req(OP_ENQUEUE, 2, 0, 0, 0, 0, 0), 1'b1,
                                       status(0, 1, 1, 1, 1, 1, 1)});
        script.push_back(script_row_t'{make_req(OP_ENQUEUE, 1, 0, 0, 0, 0, 0), 1'b1,
                                       status(0, 1, 1, 1, 1, 1, 2)});
        script.push_back(script_row_t'{make_req(OP_ENQUEUE, 3, 0, 0, 0, 0, 0), 1'b1,
                                       status(0, 1, 1, 1, 1, 1, 2)});
        // zero count holds, zero period
        script.push_back(script_row_t'{make_req(OP_START, 0, 0, 0, 255, 0, 1), 1'b1,
                                       status(0, 1, 0, 1, 1, 1, 2)});
        script.push_back(script_row_t'{make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_START, 0, 255, 16'hFFFF, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 1, 1, 1, 2)});
        script.push_back(script_row_t'{make_req(OP_START, 0, 1, 0, 128, 128, 128), 1'b1,
                                       status(0, 0, 0, 1, 1, 1, 2)});
        script.push_back(script_row_t'{make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_STOP, 0, 0, 0, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 0, 0, 0, 1)});
        script.push_back(script_row_t'{make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_START, 0, 2, 16'hFFFF, 0, 255, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_STOP, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // ringing without a blink holds back an enqueue until the next tick
        script.push_back(script_row_t'{make_req(OP_RING, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_ENQUEUE, 1, 0, 0, 0, 0, 0), 1'b1,
                                       status(1, 1, 1, 0, 1, 0, 1)});
        script.push_back(script_row_t'{make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back(script_row_t'{make_req(OP_STOP, 0, 0, 0, 0, 0, 0), 1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_request(script[i].req, script[i].typed, script[i].want);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: load_settings(8'd255, 16'hFFFF, 3'd7, 3'd0, 1'b1);
                1: load_settings(8'd0, 16'd0, 3'd0, 3'd7, 1'b0);
                default: load_settings(8'($urandom_range(3, 1)), 16'($urandom_range(4)),
                                       3'($urandom), 3'($urandom), 1'($urandom));
            endcase
            if (phase < 2)
            begin
                src_idle_pct = 11;
                sink_idle_pct = 87;
            end
            else if (phase < 4)
            begin
                src_idle_pct = 87;
                sink_idle_pct = 11;
            end
            else
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_request(random_request(), 1'b0, '0);
            drain();
        end

        $display("tb: %0d requests (%0d directed) over %0d register settings",
                 requests_sent, script.size(), RANDOM_PHASES + 1);
        $display("tb: %0d statuses checked, %0d mismatches", statuses_checked, errors);
        if (errors == 0)
            $display("tb_alert_blink_sequencer: done, clean");
        else
            $display("tb_alert_blink_sequencer: done, errors");
        $finish;
    end

endmodule
